@@ hw/rtl/glr_pkg.sv @@
// glr_pkg: shared constants, enums and helpers of the gradient line rasterizer
// no dependencies
package glr_pkg;
	localparam int SCREEN_WIDTH_DEF  = 1920;
	localparam int SCREEN_HEIGHT_DEF = 1080;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int COORD_W    = 16;
	localparam int COLOR_W    = 8;
	localparam int CHANNELS   = 5;
	localparam int DELTA_W    = COORD_W + 1;
	localparam int MAG_W      = 16;
	localparam int SQ_IN_W    = 17;
	localparam int S_W        = 34;
	localparam int ROOT_GUARD = 15;
	localparam int ROOT_W     = 32;
	localparam int RAD_W      = S_W + 2 * ROOT_GUARD;
	localparam int STEP_W     = 17;
	localparam int OFFSET_W   = 27;
	localparam int COLOR_PK_W = 3 * COLOR_W;
	localparam int STRIDE_W   = 16;
	localparam int BPP_W      = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd7680;
	localparam logic [BPP_W-1:0]    BPP_RESET    = 4'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STRIDE = 1'b0,
		REG_BPP    = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_ROOT,
		ST_CMUL,
		ST_CFIX,
		ST_DIV
	} glr_state_t;

	function automatic logic [MAG_W-1:0] mag_of(input logic signed [DELTA_W-1:0] d);
		logic [DELTA_W-1:0] a;
		begin
			a = d[DELTA_W-1] ? DELTA_W'(-d) : DELTA_W'(d);
			return a[MAG_W-1:0];
		end
	endfunction
endpackage

@@ hw/rtl/glr_cmd_if.sv @@
// glr_cmd_if: command channel (segment load or pixel tick)
// depends on glr_pkg
interface glr_cmd_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic signed [glr_pkg::COORD_W-1:0]  start_x;
	logic signed [glr_pkg::COORD_W-1:0]  start_y;
	logic        [glr_pkg::COLOR_W-1:0]  start_red;
	logic        [glr_pkg::COLOR_W-1:0]  start_green;
	logic        [glr_pkg::COLOR_W-1:0]  start_blue;
	logic signed [glr_pkg::COORD_W-1:0]  end_x;
	logic signed [glr_pkg::COORD_W-1:0]  end_y;
	logic        [glr_pkg::COLOR_W-1:0]  end_red;
	logic        [glr_pkg::COLOR_W-1:0]  end_green;
	logic        [glr_pkg::COLOR_W-1:0]  end_blue;

	modport source (output valid, op, start_x, start_y, start_red, start_green, start_blue,
		end_x, end_y, end_red, end_green, end_blue, input ready);
	modport sink (input valid, op, start_x, start_y, start_red, start_green, start_blue,
		end_x, end_y, end_red, end_green, end_blue, output ready);
endinterface

@@ hw/rtl/glr_pix_if.sv @@
// glr_pix_if: pixel result channel
// depends on glr_pkg
interface glr_pix_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [glr_pkg::COORD_W-1:0]     pixel_x;
	logic signed [glr_pkg::COORD_W-1:0]     pixel_y;
	logic                                   in_bounds;
	logic        [glr_pkg::OFFSET_W-1:0]    byte_offset;
	logic        [glr_pkg::COLOR_PK_W-1:0]  pixel_color;
	logic                                   last;

	modport source (output valid, pixel_x, pixel_y, in_bounds, byte_offset, pixel_color, last,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, in_bounds, byte_offset, pixel_color, last,
		output ready);
endinterface

@@ hw/rtl/gradient_line_rasterizer.sv @@
// gradient_line_rasterizer: segment walker with per-channel fixed-point gradient
// load: computes the step count and per-channel increments using one shared
//   17x17 multiplier, a 2-bit-per-cycle root loop and a 1-bit-per-cycle divider; not ready meanwhile
// tick: one per cycle unless the output is stalled, pixel registered, visible the cycle after acceptance
// reset (arst_n low): no segment loaded, stride 7680, 4 bytes per pixel, output empty
module gradient_line_rasterizer #(
	parameter int SCREEN_WIDTH  = glr_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = glr_pkg::SCREEN_HEIGHT_DEF,
	parameter int FRACTION_BITS = glr_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [glr_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [glr_pkg::CFG_DATA_W-1:0]    wr_data,
	glr_cmd_if.sink                           cmd,
	glr_pix_if.source                         pixel
);
	import glr_pkg::*;

	localparam int NUM_W  = MAG_W + FRACTION_BITS + ROOT_GUARD;
	localparam int INC_W  = FRACTION_BITS + 10;
	localparam int ACC_W  = FRACTION_BITS + 20;
	localparam int CNT_W  = $clog2(NUM_W);
	localparam int CH_W   = $clog2(CHANNELS);
	localparam int REM_W  = ROOT_W + 1;

	glr_state_t state_q, state_nx;

	logic [CNT_W-1:0]               cnt_q;
	logic [CH_W-1:0]                ch_q;
	logic [S_W-1:0]                 sq_q, s_q, sum_s;
	logic [RAD_W-1:0]               rad_q;
	logic [REM_W-1:0]               rem_q;
	logic [ROOT_W-1:0]              root_q, drem_q, drem_nx;
	logic [NUM_W-1:0]               num_q, num_nx;
	logic [CHANNELS-1:0][COORD_W-1:0] org_q;
	logic signed [DELTA_W-1:0]      delta_q [CHANNELS];
	logic [INC_W-1:0]               inc_q [CHANNELS];
	logic [CHANNELS-1:0][ACC_W-1:0] acc_q;
	logic                           active_q;
	logic [STEP_W-1:0]              idx_q, total_q, idx_inc;
	logic [STRIDE_W-1:0]            stride_q;
	logic [BPP_W-1:0]               bpp_q;

	logic                           out_valid_q;
	logic signed [COORD_W-1:0]      out_x_q, out_y_q;
	logic                           out_in_q, out_last_q;
	logic [OFFSET_W-1:0]            out_off_q;
	logic [COLOR_PK_W-1:0]          out_color_q;

	logic [SQ_IN_W-1:0]             mul_a, isq;
	logic [2*SQ_IN_W-1:0]           prod;
	logic [REM_W+1:0]               r_rt, trial;
	logic [REM_W-1:0]               r_dv;
	logic                           ge;
	logic [INC_W-1:0]               q_mag, inc_val;
	logic                           cmd_acc, load_fire, tick_fire;

	logic signed [COORD_W-1:0]      p_x, p_y;
	logic                           p_in;
	logic [OFFSET_W-1:0]            p_off;
	logic [COLOR_PK_W-1:0]          p_color;

	glr_pixel #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.FRACTION_BITS (FRACTION_BITS)
	) u_pixel (
		.org       (org_q),
		.acc       (acc_q),
		.stride    (stride_q),
		.bpp       (bpp_q),
		.px        (p_x),
		.py        (p_y),
		.on_screen (p_in),
		.offset    (p_off),
		.color     (p_color)
	);

	// shared datapath
	always_comb begin
		isq     = root_q[ROOT_W-1:ROOT_GUARD];
		prod    = mul_a * mul_a;
		sum_s   = sq_q + S_W'(prod);
		r_rt    = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial   = {1'b0, root_q, 2'b01};
		r_dv    = {drem_q, num_q[NUM_W-1]};
		ge      = r_dv >= {1'b0, root_q};
		drem_nx = ge ? ROOT_W'(r_dv - {1'b0, root_q}) : r_dv[ROOT_W-1:0];
		num_nx  = {num_q[NUM_W-2:0], ge};
		q_mag   = num_nx[INC_W-1:0];
		inc_val = delta_q[0][DELTA_W-1] ? INC_W'(-q_mag) : q_mag;
		idx_inc = idx_q + 1'b1;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (load_fire) state_nx = ST_SQX;
			ST_SQX:  state_nx = ST_SQY;
			ST_SQY:  state_nx = (sum_s == '0) ? ST_IDLE : ST_ROOT;
			ST_ROOT: if (cnt_q == '0) state_nx = ST_CMUL;
			ST_CMUL: state_nx = ST_CFIX;
			ST_CFIX: state_nx = ST_DIV;
			ST_DIV:  if (cnt_q == '0 && ch_q == CH_W'(CHANNELS - 1)) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		case (state_q)
			ST_SQX:  mul_a = SQ_IN_W'(mag_of(delta_q[0]));
			ST_SQY:  mul_a = SQ_IN_W'(mag_of(delta_q[1]));
			default: mul_a = isq;
		endcase
		cmd.ready = (state_q == ST_IDLE) && (!out_valid_q || pixel.ready);
		cmd_acc   = cmd.valid && cmd.ready;
		load_fire = cmd_acc && (op_t'(cmd.op) == OP_LOAD);
		tick_fire = cmd_acc && (op_t'(cmd.op) == OP_TICK) && active_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= 1'b0;
			idx_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			stride_q    <= STRIDE_RESET;
			bpp_q       <= BPP_RESET;
			cnt_q       <= '0;
			ch_q        <= '0;
		end else begin
			state_q <= state_nx;
			if (wr_en) begin
				case (cfg_reg_t'(wr_index))
					REG_STRIDE: stride_q <= wr_data[STRIDE_W-1:0];
					REG_BPP:    bpp_q    <= wr_data[BPP_W-1:0];
					default:    ;
				endcase
			end
			if (load_fire) begin
				active_q <= 1'b0;
				idx_q    <= '0;
			end
			if (tick_fire) begin
				idx_q <= idx_inc;
				if (idx_inc >= total_q)
					active_q <= 1'b0;
			end
			if (tick_fire)
				out_valid_q <= 1'b1;
			else if (pixel.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_SQY:  cnt_q <= CNT_W'(ROOT_W - 1);
				ST_ROOT: cnt_q <= cnt_q - 1'b1;
				ST_CFIX: begin
					total_q <= isq + STEP_W'(sq_q < s_q);
					cnt_q   <= CNT_W'(NUM_W - 1);
					ch_q    <= '0;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						cnt_q <= CNT_W'(NUM_W - 1);
						ch_q  <= ch_q + 1'b1;
						if (ch_q == CH_W'(CHANNELS - 1))
							active_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_fire) begin
			org_q[0]   <= cmd.start_x;
			org_q[1]   <= cmd.start_y;
			org_q[2]   <= COORD_W'(cmd.start_red);
			org_q[3]   <= COORD_W'(cmd.start_green);
			org_q[4]   <= COORD_W'(cmd.start_blue);
			delta_q[0] <= {cmd.end_x[COORD_W-1], cmd.end_x} - {cmd.start_x[COORD_W-1], cmd.start_x};
			delta_q[1] <= {cmd.end_y[COORD_W-1], cmd.end_y} - {cmd.start_y[COORD_W-1], cmd.start_y};
			delta_q[2] <= DELTA_W'(cmd.end_red)   - DELTA_W'(cmd.start_red);
			delta_q[3] <= DELTA_W'(cmd.end_green) - DELTA_W'(cmd.start_green);
			delta_q[4] <= DELTA_W'(cmd.end_blue)  - DELTA_W'(cmd.start_blue);
			acc_q      <= '0;
		end
		if (tick_fire) begin
			for (int k = 0; k < CHANNELS; k++)
				acc_q[k] <= acc_q[k] + {{(ACC_W-INC_W){inc_q[k][INC_W-1]}}, inc_q[k]};
			out_x_q     <= p_x;
			out_y_q     <= p_y;
			out_in_q    <= p_in;
			out_off_q   <= p_off;
			out_color_q <= p_color;
			out_last_q  <= (idx_inc == total_q);
		end
		case (state_q)
			ST_SQX: sq_q <= S_W'(prod);
			ST_SQY: begin
				s_q    <= sum_s;
				rad_q  <= {sum_s, {(2*ROOT_GUARD){1'b0}}};
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				rad_q <= {rad_q[RAD_W-3:0], 2'b00};
				if (r_rt >= trial) begin
					rem_q  <= REM_W'(r_rt - trial);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= r_rt[REM_W-1:0];
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			ST_CMUL: sq_q <= S_W'(prod);
			ST_CFIX: begin
				num_q  <= {mag_of(delta_q[0]), {(NUM_W-MAG_W){1'b0}}};
				drem_q <= '0;
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					inc_q[ch_q] <= inc_val;
					for (int k = 0; k < CHANNELS - 1; k++)
						delta_q[k] <= delta_q[k+1];
					num_q  <= {mag_of(delta_q[1]), {(NUM_W-MAG_W){1'b0}}};
					drem_q <= '0;
				end else begin
					num_q  <= num_nx;
					drem_q <= drem_nx;
				end
			end
			default: ;
		endcase
	end

	assign pixel.valid       = out_valid_q;
	assign pixel.pixel_x     = out_x_q;
	assign pixel.pixel_y     = out_y_q;
	assign pixel.in_bounds   = out_in_q;
	assign pixel.byte_offset = out_off_q;
	assign pixel.pixel_color = out_color_q;
	assign pixel.last        = out_last_q;
endmodule

@@ hw/rtl/glr_pixel.sv @@
// glr_pixel: per-tick pixel values from origins and accumulators, clip test, byte offset
// depends on glr_pkg
module glr_pixel #(
	parameter int SCREEN_WIDTH  = glr_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = glr_pkg::SCREEN_HEIGHT_DEF,
	parameter int FRACTION_BITS = glr_pkg::FRACTION_BITS_DEF
) (
	input  logic [glr_pkg::CHANNELS-1:0][glr_pkg::COORD_W-1:0]   org,
	input  logic [glr_pkg::CHANNELS-1:0][FRACTION_BITS+19:0]     acc,
	input  logic [glr_pkg::STRIDE_W-1:0]                         stride,
	input  logic [glr_pkg::BPP_W-1:0]                            bpp,
	output logic signed [glr_pkg::COORD_W-1:0]                   px,
	output logic signed [glr_pkg::COORD_W-1:0]                   py,
	output logic                                                 on_screen,
	output logic [glr_pkg::OFFSET_W-1:0]                         offset,
	output logic [glr_pkg::COLOR_PK_W-1:0]                       color
);
	import glr_pkg::*;

	localparam int ACC_W = FRACTION_BITS + 20;
	localparam int VAL_W = ACC_W - FRACTION_BITS;
	localparam int XW    = $clog2(SCREEN_WIDTH + 1);
	localparam int YW    = $clog2(SCREEN_HEIGHT + 1);

	logic [CHANNELS-1:0][VAL_W-1:0] v;
	logic [ACC_W-1:0]               a;
	logic [VAL_W-1:0]               t;
	logic [YW+STRIDE_W-1:0]         prod_y;
	logic [XW+BPP_W-1:0]            prod_x;

	always_comb begin
		for (int k = 0; k < CHANNELS; k++) begin
			a = acc[k][ACC_W-1] ? ACC_W'(-acc[k]) : acc[k];
			t = a[ACC_W-1:FRACTION_BITS];
			if (acc[k][ACC_W-1])
				t = VAL_W'(-t);
			v[k] = VAL_W'({{(VAL_W-COORD_W){org[k][COORD_W-1]}}, org[k]}) + t;
		end
		on_screen = !v[0][VAL_W-1] && (v[0] < VAL_W'(SCREEN_WIDTH)) &&
			!v[1][VAL_W-1] && (v[1] < VAL_W'(SCREEN_HEIGHT));
		prod_y = v[1][YW-1:0] * stride;
		prod_x = v[0][XW-1:0] * bpp;
		offset = on_screen ? (OFFSET_W'(prod_y) + OFFSET_W'(prod_x)) : '0;
		px     = v[0][COORD_W-1:0];
		py     = v[1][COORD_W-1:0];
		color  = {v[2][COLOR_W-1:0], v[3][COLOR_W-1:0], v[4][COLOR_W-1:0]};
	end
endmodule

@@ hw/rtl/glr_checker.sv @@
// glr_checker: port-level assertions for gradient_line_rasterizer, with its bind
// depends on glr_pkg and gradient_line_rasterizer
module glr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              in_op,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [glr_pkg::OFFSET_W-1:0]      out_offset,
	input logic                              out_in_bounds
);
	import glr_pkg::*;

	// no new transaction taken while a pixel is stuck at the output
	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("command accepted while pixel stalled");

	// a load keeps the command side busy for the next cycle
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (op_t'(in_op) == OP_LOAD)) |=> !in_ready)
		else $error("ready right after a load");

	// a load never produces a pixel
	a_load_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (op_t'(in_op) == OP_LOAD) && !out_valid) |=> !out_valid)
		else $error("pixel produced by a load");

	// clipped pixels carry a zero offset
	a_clip_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_in_bounds) |-> (out_offset == '0))
		else $error("nonzero offset on clipped pixel");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_offset)))
		else $error("stalled pixel changed");
endmodule

bind gradient_line_rasterizer glr_checker u_glr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (cmd.valid),
	.in_ready      (cmd.ready),
	.in_op         (cmd.op),
	.out_valid     (pixel.valid),
	.out_ready     (pixel.ready),
	.out_offset    (pixel.byte_offset),
	.out_in_bounds (pixel.in_bounds)
);
